/* rtl/core/lsf_pkg.sv */
// lsf_pkg: fixed widths and reset values for the largest square finder
// no dependencies; imported by the top level
package lsf_pkg;

  localparam int CFG_W         = 11;    // row width register
  localparam int CORNER_W      = 10;    // corner coordinate fields
  localparam int SIZE_OUT_W    = 11;    // best size field
  localparam int ROW_WIDTH_RST = 1024;  // row width after reset

endpackage

/* rtl/core/lsf_ram.sv */
// lsf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* rtl/core/largest_square_finder.sv */
// largest_square_finder: largest all-ones square in a raster-order binary grid
// depends on lsf_pkg (widths, reset values) and lsf_ram (previous-row line store)
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_ready, in_cell_bit, in_last_cell | in
//   result  | out_valid, out_ready, out_found, out_corner_x,| out
//           | out_corner_y, out_best_size                |
//   config  | cfg_valid, cfg_ready, cfg_row_width        | in
//
// one cell is taken every cycle unless stalled; the line store is read at the edge
// that takes a cell, which then passes through the compute stage registers, and a
// last cell completing there loads the result register that raises the result
// request. the only stall is a last cell meeting a result request not yet taken.
// synchronous active-low reset; the line store needs no clearing pass, a
// high-water mark of columns written in the current grid masks stale entries.
module largest_square_finder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // cell requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cell_bit,
  input  logic                          in_last_cell,
  // result requests
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [lsf_pkg::CORNER_W-1:0]  out_corner_x,
  output logic [lsf_pkg::CORNER_W-1:0]  out_corner_y,
  output logic [lsf_pkg::SIZE_OUT_W-1:0] out_best_size,
  // row width register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsf_pkg::CFG_W-1:0]     cfg_row_width
);

  import lsf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int RW = $clog2(MAX_HEIGHT + 1);  // row count, saturates at MAX_HEIGHT
  localparam int SW = $clog2(MAX_WIDTH + 1);   // square side

  // ---------------------------------------------------------------------------
  // row width register
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] row_width_r;
  logic [CW:0]      width_eff;
  logic [CFG_W-1:0] width_lo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= CFG_W'(ROW_WIDTH_RST);
    end else if (cfg_valid) begin
      row_width_r <= cfg_row_width;
    end
  end

  // zero acts as one, anything above MAX_WIDTH acts as MAX_WIDTH
  always_comb begin
    width_lo = (row_width_r == '0) ? CFG_W'(1) : row_width_r;
    if (32'(width_lo) > 32'(MAX_WIDTH)) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(width_lo);
    end
  end

  // ---------------------------------------------------------------------------
  // read stage: raster counters and line store read address
  // ---------------------------------------------------------------------------
  logic          in_fire;
  logic          s1_fire;
  logic          s1_write;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW:0]   col_inc;

  assign in_fire = in_valid && in_ready;
  assign col_inc = {1'b0, col_r} + (CW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (in_last_cell) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_inc >= width_eff) begin
        // wrap, also catches a column left past a narrowed width
        col_r <= '0;
        if (32'(row_r) < 32'(MAX_HEIGHT)) begin
          row_r <= row_r + RW'(1);
        end
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // compute stage registers
  // ---------------------------------------------------------------------------
  logic          s1_valid_r;
  logic          s1_cell_r;
  logic          s1_last_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_byp_r;       // read collided with the write of the cell before
  logic [SW-1:0] s1_byp_data_r;
  logic [SW-1:0] size;
  logic [SW-1:0] ram_rdata;
  logic          out_valid_r;

  // a last cell needs the result register free before it completes
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r     <= in_cell_bit;
      s1_last_r     <= in_last_cell;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_byp_r      <= s1_write && (s1_col_r == col_r);
      s1_byp_data_r <= size;
    end
  end

  lsf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .we      (s1_write),
    .waddr   (s1_col_r),
    .wdata   (size),
    .re      (in_fire),
    .raddr   (col_r),
    .rdata_r (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // compute stage: size = cell ? 1 + min(up, left, up-left) : 0
  // ---------------------------------------------------------------------------
  logic          in_range;
  logic [CW:0]   hwm_r;          // columns written so far in this grid
  logic [SW-1:0] left_r;
  logic [SW-1:0] upleft_r;
  logic [SW-1:0] best_r;
  logic [CW-1:0] best_x_r;
  logic [RW-1:0] best_y_r;
  logic [SW-1:0] up;
  logic [SW-1:0] lf;
  logic [SW-1:0] ul;
  logic [SW-1:0] min_a;
  logic [SW-1:0] min3;
  logic [CW:0]   col_next;
  logic          better;
  logic [SW-1:0] best_nxt;
  logic [CW-1:0] best_x_nxt;
  logic [RW-1:0] best_y_nxt;
  logic [CW:0]   cx_wide;
  logic [RW-1:0] cy_wide;

  // rows at or past MAX_HEIGHT read as clear and store nothing
  assign in_range = 32'(s1_row_r) < 32'(MAX_HEIGHT);
  assign s1_write = s1_fire && in_range;
  assign col_next = {1'b0, s1_col_r} + (CW+1)'(1);

  always_comb begin
    // entries beyond the high-water mark belong to an earlier grid
    if ((s1_row_r != '0) && ({1'b0, s1_col_r} < hwm_r)) begin
      up = s1_byp_r ? s1_byp_data_r : ram_rdata;
    end else begin
      up = '0;
    end
    lf    = (s1_col_r != '0) ? left_r : '0;
    ul    = ((s1_col_r != '0) && (s1_row_r != '0)) ? upleft_r : '0;
    min_a = (up < lf) ? up : lf;
    min3  = (min_a < ul) ? min_a : ul;
    size  = (s1_cell_r && in_range) ? (min3 + SW'(1)) : '0;
  end

  // corner of the new square, strictly larger only so the earliest one stays
  always_comb begin
    better     = in_range && (size > best_r);
    cx_wide    = {1'b0, s1_col_r} - (CW+1)'(size) + (CW+1)'(1);
    cy_wide    = s1_row_r - RW'(size) + RW'(1);
    best_nxt   = better ? size : best_r;
    best_x_nxt = better ? cx_wide[CW-1:0] : best_x_r;
    best_y_nxt = better ? cy_wide : best_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r    <= '0;
      left_r   <= '0;
      upleft_r <= '0;
      best_r   <= '0;
      best_x_r <= '0;
      best_y_r <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        // grid done, start clean
        hwm_r    <= '0;
        left_r   <= '0;
        upleft_r <= '0;
        best_r   <= '0;
        best_x_r <= '0;
        best_y_r <= '0;
      end else begin
        if (in_range) begin
          left_r   <= size;
          upleft_r <= up;
          if (col_next > hwm_r) begin
            hwm_r <= col_next;
          end
        end
        best_r   <= best_nxt;
        best_x_r <= best_x_nxt;
        best_y_r <= best_y_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic                  found_r;
  logic [CORNER_W-1:0]   corner_x_r;
  logic [CORNER_W-1:0]   corner_y_r;
  logic [SIZE_OUT_W-1:0] best_size_r;
  logic [31:0]           cx32;
  logic [31:0]           cy32;
  logic [31:0]           bs32;
  logic                  found_nxt;

  assign cx32      = 32'(best_x_nxt);
  assign cy32      = 32'(best_y_nxt);
  assign bs32      = 32'(best_nxt);
  assign found_nxt = best_nxt != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      found_r     <= found_nxt;
      corner_x_r  <= found_nxt ? cx32[CORNER_W-1:0] : '0;
      corner_y_r  <= found_nxt ? cy32[CORNER_W-1:0] : '0;
      best_size_r <= bs32[SIZE_OUT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = found_r;
  assign out_corner_x  = corner_x_r;
  assign out_corner_y  = corner_y_r;
  assign out_best_size = best_size_r;

endmodule
